[hw/rtl/tbci_pkg.sv]
package tbci_pkg;

    // field widths of one collision event and one result
    localparam int VEL_W    = 16;
    localparam int MASS_W   = 16;
    localparam int NRM_W    = 16;
    localparam int COEF_W   = 15;
    localparam int FRAC_W   = 14;
    localparam int ENERGY_W = 48;

    localparam int S_DATA_W = 160;
    localparam int M_DATA_W = 160;

    // impulse divider: dividend |j|*mb, divisor ma+mb, quotient never above |j|
    localparam int DIV_NUM_W  = 51;
    localparam int DIV_DEN_W  = MASS_W + 1;
    localparam int DIV_QUO_W  = 35;
    localparam int DIV_BPS    = 5;
    localparam int DIV_STAGES = DIV_QUO_W / DIV_BPS;

    typedef struct packed {
        logic        [COEF_W-1:0] hardness;
        logic        [COEF_W-1:0] restitution;
        logic signed [NRM_W-1:0]  ny;
        logic signed [NRM_W-1:0]  nx;
        logic        [MASS_W-1:0] mb;
        logic        [MASS_W-1:0] ma;
        logic signed [VEL_W-1:0]  by;
        logic signed [VEL_W-1:0]  bx;
        logic signed [VEL_W-1:0]  ay;
        logic signed [VEL_W-1:0]  ax;
    } t_evt;

    typedef struct packed {
        logic signed [VEL_W-1:0] by;
        logic signed [VEL_W-1:0] bx;
        logic signed [VEL_W-1:0] ay;
        logic signed [VEL_W-1:0] ax;
    } t_vel4;

    typedef struct packed {
        logic                   neg;
        logic [DIV_QUO_W-1:0]   mag;
    } t_jinfo;

endpackage

[hw/rtl/tbci_div.sv]
module tbci_div (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic [tbci_pkg::DIV_NUM_W-1:0]     i_num,
    input  logic [tbci_pkg::DIV_DEN_W-1:0]     i_den,
    output logic [tbci_pkg::DIV_QUO_W-1:0]     o_quo,
    output logic [tbci_pkg::DIV_DEN_W-1:0]     o_rem
);

    localparam int NUM_W = tbci_pkg::DIV_NUM_W;
    localparam int DEN_W = tbci_pkg::DIV_DEN_W;
    localparam int QUO_W = tbci_pkg::DIV_QUO_W;
    localparam int BPS   = tbci_pkg::DIV_BPS;
    localparam int NST   = tbci_pkg::DIV_STAGES;

    logic [DEN_W-1:0] r_rem [NST];
    logic [QUO_W-1:0] r_low [NST];
    logic [QUO_W-1:0] r_quo [NST];
    logic [DEN_W-1:0] r_den [NST];

    logic [DEN_W-1:0] n_rem [NST];
    logic [QUO_W-1:0] n_low [NST];
    logic [QUO_W-1:0] n_quo [NST];

    logic [DEN_W-1:0] w_src_rem [NST];
    logic [QUO_W-1:0] w_src_low [NST];
    logic [QUO_W-1:0] w_src_quo [NST];
    logic [DEN_W-1:0] w_src_den [NST];

    // the top dividend bits already sit below the divisor
    for (genvar g = 0; g < NST; g++) begin : g_src
        if (g == 0) begin : g_first
            assign w_src_rem[g] = DEN_W'(i_num[NUM_W-1:QUO_W]);
            assign w_src_low[g] = i_num[QUO_W-1:0];
            assign w_src_quo[g] = '0;
            assign w_src_den[g] = i_den;
        end else begin : g_rest
            assign w_src_rem[g] = r_rem[g-1];
            assign w_src_low[g] = r_low[g-1];
            assign w_src_quo[g] = r_quo[g-1];
            assign w_src_den[g] = r_den[g-1];
        end
    end

    // restoring division, DIV_BPS (5) quotient bits per stage
    always_comb begin
        logic [DEN_W:0]   t;
        logic [DEN_W-1:0] rem;
        logic [QUO_W-1:0] low;
        logic [QUO_W-1:0] quo;
        for (int s = 0; s < NST; s++) begin
            rem = w_src_rem[s];
            low = w_src_low[s];
            quo = w_src_quo[s];
            for (int b = 0; b < BPS; b++) begin
                t   = {rem, low[QUO_W-1]};
                low = {low[QUO_W-2:0], 1'b0};
                if (t >= {1'b0, w_src_den[s]}) begin
                    t   = t - {1'b0, w_src_den[s]};
                    quo = {quo[QUO_W-2:0], 1'b1};
                end else begin
                    quo = {quo[QUO_W-2:0], 1'b0};
                end
                rem = t[DEN_W-1:0];
            end
            n_rem[s] = rem;
            n_low[s] = low;
            n_quo[s] = quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < NST; s++) begin
                r_rem[s] <= n_rem[s];
                r_low[s] <= n_low[s];
                r_quo[s] <= n_quo[s];
                r_den[s] <= w_src_den[s];
            end
        end
    end

    assign o_quo = r_quo[NST-1];
    assign o_rem = r_rem[NST-1];

endmodule

[hw/rtl/two_body_collision_impulse_unit.sv]
// channel  dir  beat fields (low bit up)
// s_axis   in   ax, ay, bx, by, mass_a, mass_b, normal_x, normal_y, restitution, hardness
// m_axis   out  new ax, ay, bx, by, impact_energy_a, impact_energy_b
//
// one event accepted per cycle while the output is not stalled; stages: dot product, gain, impulse
// magnitude, 7-stage divider for the mass split, velocity update, energy
// the pipeline is 25 register stages deep, of which the divider takes 7
// reset clears only the valid bits; data registers hold no reset
// a stalled output freezes the whole pipe, so nothing is dropped or repeated
module two_body_collision_impulse_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // ax[15:0] ay[31:16] bx[47:32] by[63:48] mass_a[79:64] mass_b[95:80]
    // normal_x[111:96] normal_y[127:112] restitution[142:128] hardness[157:143] zero
    input  logic [tbci_pkg::S_DATA_W-1:0]   i_s_tdata,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // new_vel_a_x[15:0] new_vel_a_y[31:16] new_vel_b_x[47:32] new_vel_b_y[63:48]
    // impact_energy_a[111:64] impact_energy_b[159:112]
    output logic [tbci_pkg::M_DATA_W-1:0]   o_m_tdata
);

    localparam int LAST  = 24;
    localparam int DIV_O = 13;   // stage at which the divider result is valid

    logic [LAST:0]          r_vld;
    tbci_pkg::t_evt         r_evt [23];
    tbci_pkg::t_evt         w_in;
    logic                   w_en;

    // stage registers
    logic signed [16:0] r_dx, r_dy;
    logic signed [32:0] r_pdx, r_pdy;
    logic signed [33:0] r_d;
    logic signed [49:0] r_p;
    logic signed [35:0] r_j;
    tbci_pkg::t_jinfo   r_ji [5:DIV_O];
    logic [tbci_pkg::DIV_NUM_W-1:0] r_num;
    logic [tbci_pkg::DIV_DEN_W-1:0] r_msum;
    logic [tbci_pkg::DIV_QUO_W-1:0] w_quo;
    logic [tbci_pkg::DIV_DEN_W-1:0] w_rem;
    logic [tbci_pkg::DIV_QUO_W-1:0] r_qam, r_qbm;
    logic               r_qneg;
    logic signed [35:0] r_qa, r_qb;
    logic signed [51:0] r_pax, r_pay, r_pbx, r_pby;
    logic signed [23:0] r_dvax, r_dvay, r_dvbx, r_dvby;
    tbci_pkg::t_vel4    r_nv [18:LAST];
    logic signed [16:0] r_eax, r_eay, r_ebx, r_eby;
    logic [33:0]        r_sax, r_say, r_sbx, r_sby;
    logic [34:0]        r_d2a, r_d2b;
    logic [50:0]        r_ta, r_tb;
    logic [42:0]        r_hia, r_hib;
    logic [37:0]        r_loa, r_lob;
    logic [tbci_pkg::ENERGY_W-1:0] r_ea, r_eb;

    // next values
    logic signed [49:0] n_jr;
    logic signed [51:0] n_ra, n_rb, n_rc, n_rd;
    tbci_pkg::t_vel4    n_nv;
    logic               w_mzero;

    function automatic logic signed [15:0] sat_vel(input logic signed [24:0] x);
        if (x > 25'sd32767) begin
            return 16'sh7fff;
        end else if (x < -25'sd32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    assign w_in = tbci_pkg::t_evt'(i_s_tdata[157:0]);

    // whole pipe moves unless a result is waiting on a stalled sink
    assign w_en       = !(r_vld[LAST] && !i_m_tready);
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[LAST];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], i_s_tvalid};
        end
    end

    // round half up at bit 14 of the gained dot product
    assign n_jr = r_p + 50'sd8192;
    // round half up at bit 28 of impulse times normal
    assign n_ra = r_pax + 52'sd134217728;
    assign n_rb = r_pay + 52'sd134217728;
    assign n_rc = r_pbx + 52'sd134217728;
    assign n_rd = r_pby + 52'sd134217728;

    assign w_mzero = (r_evt[DIV_O].ma == '0) && (r_evt[DIV_O].mb == '0);

    always_comb begin
        n_nv.ax = sat_vel(25'(r_evt[17].ax) + 25'(r_dvax));
        n_nv.ay = sat_vel(25'(r_evt[17].ay) + 25'(r_dvay));
        n_nv.bx = sat_vel(25'(r_evt[17].bx) - 25'(r_dvbx));
        n_nv.by = sat_vel(25'(r_evt[17].by) - 25'(r_dvby));
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_evt[0] <= w_in;
            for (int s = 1; s < 23; s++) begin
                r_evt[s] <= r_evt[s-1];
            end
            // relative velocity
            r_dx <= 17'(w_in.bx) - 17'(w_in.ax);
            r_dy <= 17'(w_in.by) - 17'(w_in.ay);
            // along the normal
            r_pdx <= r_dx * r_evt[0].nx;
            r_pdy <= r_dy * r_evt[0].ny;
            r_d   <= 34'(r_pdx) + 34'(r_pdy);
            // times (1 + e), gain needs 16 bits once e reaches 1.0
            r_p   <= 50'(r_d) * $signed({1'b0, 16'(r_evt[2].restitution) + 16'd16384});
            r_j   <= n_jr[49:14];
            // sign and magnitude for the divider
            r_ji[5].neg <= r_j[35];
            r_ji[5].mag <= r_j[35] ? 35'(-r_j) : r_j[34:0];
            for (int s = 6; s <= DIV_O; s++) begin
                r_ji[s] <= r_ji[s-1];
            end
            r_num  <= r_ji[5].mag * r_evt[5].mb;
            r_msum <= 17'(r_evt[5].ma) + 17'(r_evt[5].mb);
            // split: qb = |j| - qa - 1 when the division left a remainder
            r_qneg <= r_ji[DIV_O].neg;
            if (w_mzero) begin
                r_qam <= '0;
                r_qbm <= '0;
            end else begin
                r_qam <= w_quo;
                r_qbm <= r_ji[DIV_O].mag - w_quo - 35'(w_rem != '0);
            end
            r_qa <= r_qneg ? -$signed({1'b0, r_qam}) : $signed({1'b0, r_qam});
            r_qb <= r_qneg ? -$signed({1'b0, r_qbm}) : $signed({1'b0, r_qbm});
            r_pax <= r_qa * r_evt[15].nx;
            r_pay <= r_qa * r_evt[15].ny;
            r_pbx <= r_qb * r_evt[15].nx;
            r_pby <= r_qb * r_evt[15].ny;
            r_dvax <= n_ra[51:28];
            r_dvay <= n_rb[51:28];
            r_dvbx <= n_rc[51:28];
            r_dvby <= n_rd[51:28];
            r_nv[18] <= n_nv;
            for (int s = 19; s <= LAST; s++) begin
                r_nv[s] <= r_nv[s-1];
            end
            // energy: velocity change, squared, times mass and hardness
            r_eax <= 17'(r_evt[18].ax) - 17'(r_nv[18].ax);
            r_eay <= 17'(r_evt[18].ay) - 17'(r_nv[18].ay);
            r_ebx <= 17'(r_evt[18].bx) - 17'(r_nv[18].bx);
            r_eby <= 17'(r_evt[18].by) - 17'(r_nv[18].by);
            r_sax <= 34'(r_eax) * 34'(r_eax);
            r_say <= 34'(r_eay) * 34'(r_eay);
            r_sbx <= 34'(r_ebx) * 34'(r_ebx);
            r_sby <= 34'(r_eby) * 34'(r_eby);
            r_d2a <= {1'b0, r_sax} + {1'b0, r_say};
            r_d2b <= {1'b0, r_sbx} + {1'b0, r_sby};
            r_ta  <= r_d2a * r_evt[21].ma;
            r_tb  <= r_d2b * r_evt[21].mb;
            // split at bit 23 to keep each multiply narrow
            r_hia <= r_ta[50:23] * r_evt[22].hardness;
            r_loa <= r_ta[22:0] * r_evt[22].hardness;
            r_hib <= r_tb[50:23] * r_evt[22].hardness;
            r_lob <= r_tb[22:0] * r_evt[22].hardness;
            // stays under 2^44, so the top of the range is never reached
            r_ea  <= 48'(r_hia) + 48'(r_loa[37:23]);
            r_eb  <= 48'(r_hib) + 48'(r_lob[37:23]);
        end
    end

    tbci_div u_div (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_num),
        .i_den (r_msum),
        .o_quo (w_quo),
        .o_rem (w_rem)
    );

    assign o_m_tdata = {r_eb, r_ea, r_nv[LAST].by, r_nv[LAST].bx,
                        r_nv[LAST].ay, r_nv[LAST].ax};

endmodule
